// ===== sv/buddy_page_allocator_assert.svh =====
// assertion macros for the buddy page allocator
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("buddy allocator check failed");
`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("buddy allocator check failed");
`else
`define BPA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/bpa_pkg.sv =====
// types and constants of the buddy page allocator
`default_nettype none
package bpa_pkg;
    localparam int MAX_PAGES_DEF   = 4096;
    localparam int ORDER_COUNT_DEF = 11;
    localparam int ORDER_W = 4;
    localparam int FREE_W  = 13;
    localparam int COUNT_W = 13;
    localparam int BASE_W  = 36;

    localparam logic CFG_BASE_PAGE  = 1'b0;
    localparam logic CFG_PAGE_COUNT = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_NO_FREE,
        STAT_BAD_ORDER,
        STAT_BAD_INDEX
    } t_status;

    typedef enum logic {
        MODE_ALLOC,
        MODE_FREE
    } t_mode;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_POP,
        S_ALLOC_UNLINK,
        S_ALLOC_SPLIT,
        S_FREE_CHK,
        S_FREE_BUD,
        S_FREE_MERGE,
        S_PUSH1,
        S_PUSH2,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

// ===== sv/bpa_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/buddy_page_allocator.sv =====
// buddy page allocator: free lists kept in page metadata and link rams
// allocate: pop the smallest fitting list, then split down, pushing each buddy half that lies in the pool
// free: check the page, merge with each free in-pool buddy of equal order, then push the merged chunk
// errors and double frees end without touching the lists; one request at a time, ram reads are registered
// after reset a clearing pass zeroes the page metadata ram while busy is high
// results appear for one cycle on o_result_valid and cannot be stalled
`default_nettype none
`include "buddy_page_allocator_assert.svh"
module buddy_page_allocator #(
    parameter int MAX_PAGES   = bpa_pkg::MAX_PAGES_DEF,
    parameter int ORDER_COUNT = bpa_pkg::ORDER_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_mode,
    input  wire logic [bpa_pkg::ORDER_W-1:0]   i_order,
    input  wire logic [$clog2(MAX_PAGES)-1:0]  i_page_index,
    output logic                               o_result_valid,
    output logic [1:0]                         o_status,
    output logic [$clog2(MAX_PAGES)-1:0]       o_chunk_index,
    output logic [bpa_pkg::FREE_W-1:0]         o_free_pages,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic                          i_cfg_index,
    input  wire logic [bpa_pkg::BASE_W-1:0]    i_cfg_data
);
    localparam int PW = $clog2(MAX_PAGES);
    localparam int LW = PW + 1;
    localparam int OW = bpa_pkg::ORDER_W;
    localparam int MW = OW + 1;
    localparam int AW = ORDER_COUNT;
    localparam int HW = (ORDER_COUNT > 1) ? $clog2(ORDER_COUNT) : 1;
    localparam int CW = ((PW > ORDER_COUNT) ? PW : ORDER_COUNT) + 2;
    localparam int FW = bpa_pkg::FREE_W;
    localparam logic [LW-1:0] LINK_NONE = LW'(MAX_PAGES);

    bpa_pkg::t_state  r_state, n_state;
    bpa_pkg::t_mode   r_mode, n_mode;
    bpa_pkg::t_status r_status, n_status;
    logic [OW-1:0]    r_want, n_want;
    logic [OW-1:0]    r_ord, n_ord;
    logic [PW-1:0]    r_idx, n_idx;
    logic [PW-1:0]    r_tgt, n_tgt;
    logic [AW-1:0]    r_abs, n_abs;
    logic [LW-1:0]    r_h, n_h;
    logic [PW-1:0]    r_clr, n_clr;
    logic [FW-1:0]    r_ft, n_ft;
    logic [LW-1:0]    r_head [ORDER_COUNT];
    logic [bpa_pkg::BASE_W-1:0]  r_base;
    logic [bpa_pkg::COUNT_W-1:0] r_page_count;
    logic             r_out_valid;
    bpa_pkg::t_status r_out_status;
    logic [PW-1:0]    r_out_chunk;
    logic [FW-1:0]    r_out_free;

    logic          meta_we, next_we, prev_we;
    logic [PW-1:0] meta_waddr, next_waddr, prev_waddr, meta_raddr, link_raddr;
    logic [MW-1:0] meta_wdata, meta_rdata;
    logic [LW-1:0] next_wdata, prev_wdata, next_rdata, prev_rdata;
    logic          head_we;
    logic [LW-1:0] head_wdata;

    logic          accept;
    logic [CW-1:0] lim;
    logic [LW-1:0] head_val;
    logic [OW-1:0] found;
    logic          found_ok;
    logic [OW-1:0] b_ord;
    logic [CW-1:0] b_size, b_idx, b_rel, cur_size;
    logic          b_ok;
    logic [PW-1:0] bud;
    logic          merge_ok, unlink, push_more;
    logic [PW-1:0] ul_n_idx, ul_p_idx;
    logic          ul_n_ok, ul_p_ok;
    logic [LW-1:0] ul_n, ul_p;

    bpa_ram #(.WIDTH(MW), .DEPTH(MAX_PAGES)) u_meta (
        .i_clk(i_clk), .i_we(meta_we), .i_waddr(meta_waddr), .i_wdata(meta_wdata),
        .i_raddr(meta_raddr), .o_rdata(meta_rdata)
    );
    bpa_ram #(.WIDTH(LW), .DEPTH(MAX_PAGES)) u_next (
        .i_clk(i_clk), .i_we(next_we), .i_waddr(next_waddr), .i_wdata(next_wdata),
        .i_raddr(link_raddr), .o_rdata(next_rdata)
    );
    bpa_ram #(.WIDTH(LW), .DEPTH(MAX_PAGES)) u_prev (
        .i_clk(i_clk), .i_we(prev_we), .i_waddr(prev_waddr), .i_wdata(prev_wdata),
        .i_raddr(link_raddr), .o_rdata(prev_rdata)
    );

    assign busy           = (r_state != bpa_pkg::S_IDLE);
    assign accept         = start && !busy;
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_out_valid;
    assign o_status       = r_out_status;
    assign o_chunk_index  = r_out_chunk;
    assign o_free_pages   = r_out_free;

    assign lim = (CW'(r_page_count) < CW'(MAX_PAGES)) ? CW'(r_page_count) : CW'(MAX_PAGES);
    assign head_val = r_head[r_ord[HW-1:0]];
    assign cur_size = CW'(1) << r_ord;

    // smallest non-empty list at or above the requested order
    always_comb begin
        found    = '0;
        found_ok = 1'b0;
        for (int o = ORDER_COUNT - 1; o >= 0; o--) begin
            if (OW'(o) >= i_order && r_head[o] < LINK_NONE) begin
                found    = OW'(o);
                found_ok = 1'b1;
            end
        end
    end

    // buddy from the low bits of the absolute page number
    always_comb begin
        b_ord  = (r_state == bpa_pkg::S_ALLOC_SPLIT) ? OW'(r_ord - 1'b1) : r_ord;
        b_size = CW'(1) << b_ord;
        b_idx  = CW'(r_idx);
        if ((CW'(r_abs) & b_size) == '0) begin
            b_rel = b_idx + b_size;
            b_ok  = (b_rel + b_size) <= lim;
        end else begin
            b_rel = b_idx - b_size;
            b_ok  = (b_idx >= b_size) && (b_idx <= lim);
        end
        bud = PW'(b_rel);
    end

    assign merge_ok  = meta_rdata[MW-1] && (meta_rdata[OW-1:0] == r_ord);
    assign unlink    = (r_state == bpa_pkg::S_ALLOC_UNLINK) ||
                       (r_state == bpa_pkg::S_FREE_MERGE && merge_ok);
    assign ul_n      = next_rdata;
    assign ul_p      = prev_rdata;
    assign ul_n_ok   = ul_n < LINK_NONE;
    assign ul_p_ok   = ul_p < LINK_NONE;
    assign ul_n_idx  = ul_n[PW-1:0];
    assign ul_p_idx  = ul_p[PW-1:0];
    assign push_more = head_val < LINK_NONE;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bpa_pkg::S_CLEAR: begin
                if (r_clr == PW'(MAX_PAGES - 1)) begin
                    n_state = bpa_pkg::S_IDLE;
                end
            end
            bpa_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_mode == bpa_pkg::MODE_FREE) begin
                        n_state = (CW'(i_page_index) >= lim) ? bpa_pkg::S_DONE
                                                              : bpa_pkg::S_FREE_CHK;
                    end else if ((5'(i_order) >= 5'(ORDER_COUNT)) || !found_ok) begin
                        n_state = bpa_pkg::S_DONE;
                    end else begin
                        n_state = bpa_pkg::S_ALLOC_POP;
                    end
                end
            end
            bpa_pkg::S_ALLOC_POP:    n_state = bpa_pkg::S_ALLOC_UNLINK;
            bpa_pkg::S_ALLOC_UNLINK: n_state = bpa_pkg::S_ALLOC_SPLIT;
            bpa_pkg::S_ALLOC_SPLIT: begin
                if (r_ord == r_want) begin
                    n_state = bpa_pkg::S_DONE;
                end else if (b_ok) begin
                    n_state = bpa_pkg::S_PUSH1;
                end
            end
            bpa_pkg::S_FREE_CHK: begin
                n_state = meta_rdata[MW-1] ? bpa_pkg::S_DONE : bpa_pkg::S_FREE_BUD;
            end
            bpa_pkg::S_FREE_BUD: begin
                if ((5'(r_ord) + 5'd1 >= 5'(ORDER_COUNT)) || !b_ok) begin
                    n_state = bpa_pkg::S_PUSH1;
                end else begin
                    n_state = bpa_pkg::S_FREE_MERGE;
                end
            end
            bpa_pkg::S_FREE_MERGE: begin
                n_state = merge_ok ? bpa_pkg::S_FREE_BUD : bpa_pkg::S_PUSH1;
            end
            bpa_pkg::S_PUSH1: begin
                if (push_more) begin
                    n_state = bpa_pkg::S_PUSH2;
                end else begin
                    n_state = (r_mode == bpa_pkg::MODE_ALLOC) ? bpa_pkg::S_ALLOC_SPLIT
                                                               : bpa_pkg::S_DONE;
                end
            end
            bpa_pkg::S_PUSH2: begin
                n_state = (r_mode == bpa_pkg::MODE_ALLOC) ? bpa_pkg::S_ALLOC_SPLIT
                                                           : bpa_pkg::S_DONE;
            end
            bpa_pkg::S_DONE: n_state = bpa_pkg::S_IDLE;
            default:         n_state = bpa_pkg::S_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb begin
        n_mode     = r_mode;
        n_status   = r_status;
        n_want     = r_want;
        n_ord      = r_ord;
        n_idx      = r_idx;
        n_tgt      = r_tgt;
        n_abs      = r_abs;
        n_h        = r_h;
        n_clr      = r_clr;
        n_ft       = r_ft;
        meta_we    = 1'b0;
        meta_waddr = r_tgt;
        meta_wdata = {1'b1, r_ord};
        next_we    = 1'b0;
        next_waddr = ul_p_idx;
        next_wdata = ul_n;
        prev_we    = 1'b0;
        prev_waddr = ul_n_idx;
        prev_wdata = ul_p;
        head_we    = 1'b0;
        head_wdata = ul_n;
        meta_raddr = bud;
        link_raddr = bud;

        if (unlink) begin
            next_we = ul_p_ok;
            prev_we = ul_n_ok;
            head_we = !ul_p_ok;
            n_ft    = r_ft - FW'(cur_size);
        end

        case (r_state)
            bpa_pkg::S_CLEAR: begin
                meta_we    = 1'b1;
                meta_waddr = r_clr;
                meta_wdata = '0;
                n_clr      = r_clr + 1'b1;
            end
            bpa_pkg::S_IDLE: begin
                meta_raddr = i_page_index;
                if (accept) begin
                    n_mode   = bpa_pkg::t_mode'(i_mode);
                    n_want   = i_order;
                    n_idx    = i_page_index;
                    n_abs    = AW'(AW'(r_base) + AW'(i_page_index));
                    n_ord    = found;
                    n_status = bpa_pkg::STAT_OK;
                    if (i_mode == bpa_pkg::MODE_FREE) begin
                        if (CW'(i_page_index) >= lim) begin
                            n_status = bpa_pkg::STAT_BAD_INDEX;
                        end
                    end else if (5'(i_order) >= 5'(ORDER_COUNT)) begin
                        n_status = bpa_pkg::STAT_BAD_ORDER;
                    end else if (!found_ok) begin
                        n_status = bpa_pkg::STAT_NO_FREE;
                    end
                end
            end
            bpa_pkg::S_ALLOC_POP: begin
                link_raddr = head_val[PW-1:0];
                n_idx      = head_val[PW-1:0];
                n_abs      = AW'(AW'(r_base) + AW'(head_val));
            end
            bpa_pkg::S_ALLOC_UNLINK: begin
                meta_we    = 1'b1;
                meta_waddr = r_idx;
                meta_wdata = {1'b0, r_want};
            end
            bpa_pkg::S_ALLOC_SPLIT: begin
                if (r_ord != r_want) begin
                    n_ord = b_ord;
                    n_tgt = bud;
                end
            end
            bpa_pkg::S_FREE_CHK: begin
                if (meta_rdata[MW-1]) begin
                    n_status = bpa_pkg::STAT_BAD_INDEX;
                end else if (5'(meta_rdata[OW-1:0]) >= 5'(ORDER_COUNT)) begin
                    n_ord = OW'(ORDER_COUNT - 1);
                end else begin
                    n_ord = meta_rdata[OW-1:0];
                end
            end
            bpa_pkg::S_FREE_BUD: begin
                if ((5'(r_ord) + 5'd1 >= 5'(ORDER_COUNT)) || !b_ok) begin
                    n_tgt = r_idx;
                end else begin
                    n_tgt = bud;
                end
            end
            bpa_pkg::S_FREE_MERGE: begin
                if (merge_ok) begin
                    meta_we    = 1'b1;
                    meta_waddr = r_tgt;
                    meta_wdata = {1'b0, r_ord};
                    n_idx      = (r_tgt < r_idx) ? r_tgt : r_idx;
                    n_abs      = r_abs & ~AW'(cur_size);
                    n_ord      = r_ord + 1'b1;
                end else begin
                    n_tgt = r_idx;
                end
            end
            bpa_pkg::S_PUSH1: begin
                meta_we    = 1'b1;
                meta_waddr = r_tgt;
                meta_wdata = {1'b1, r_ord};
                next_we    = 1'b1;
                next_waddr = r_tgt;
                next_wdata = head_val;
                prev_we    = 1'b1;
                prev_waddr = r_tgt;
                prev_wdata = LINK_NONE;
                head_we    = 1'b1;
                head_wdata = LW'(r_tgt);
                n_h        = head_val;
                n_ft       = r_ft + FW'(cur_size);
            end
            bpa_pkg::S_PUSH2: begin
                prev_we    = 1'b1;
                prev_waddr = r_h[PW-1:0];
                prev_wdata = LW'(r_tgt);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bpa_pkg::S_CLEAR;
            r_clr        <= '0;
            r_ft         <= '0;
            r_base       <= '0;
            r_page_count <= '0;
            r_out_valid  <= 1'b0;
            for (int o = 0; o < ORDER_COUNT; o++) begin
                r_head[o] <= LINK_NONE;
            end
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_ft        <= n_ft;
            r_out_valid <= (r_state == bpa_pkg::S_DONE);
            if (head_we) begin
                r_head[r_ord[HW-1:0]] <= head_wdata;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    bpa_pkg::CFG_BASE_PAGE:  r_base       <= i_cfg_data;
                    bpa_pkg::CFG_PAGE_COUNT: r_page_count <= i_cfg_data[bpa_pkg::COUNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_status <= n_status;
        r_want   <= n_want;
        r_ord    <= n_ord;
        r_idx    <= n_idx;
        r_tgt    <= n_tgt;
        r_abs    <= n_abs;
        r_h      <= n_h;
        if (r_state == bpa_pkg::S_DONE) begin
            r_out_status <= r_status;
            r_out_chunk  <= (r_status == bpa_pkg::STAT_OK && r_mode == bpa_pkg::MODE_ALLOC)
                            ? r_idx : '0;
            r_out_free   <= r_ft;
        end
    end

    `BPA_ASSERT_IMPLY(a_result_after_done, i_clk, i_rst_n, r_out_valid, $past(r_state == bpa_pkg::S_DONE))
    `BPA_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, accept, r_state != bpa_pkg::S_IDLE)
    `BPA_ASSERT_IMPLY(a_error_chunk_zero, i_clk, i_rst_n, r_out_valid && r_out_status != bpa_pkg::STAT_OK, o_chunk_index == '0)
    `BPA_ASSERT_IMPLY(a_clear_writes_zero, i_clk, i_rst_n, r_state == bpa_pkg::S_CLEAR, meta_we && meta_wdata == '0)
    `BPA_ASSERT_NEXT(a_merge_raises_order, i_clk, i_rst_n, r_state == bpa_pkg::S_FREE_MERGE && merge_ok, r_state == bpa_pkg::S_FREE_BUD && r_ord != $past(r_ord))
endmodule
`default_nettype wire

// ===== tb/tb_buddy_page_allocator.sv =====
// self-checking testbench of the buddy page allocator: directed and random requests
`timescale 1ns / 1ps
module tb_buddy_page_allocator;
    localparam int PAGES  = bpa_pkg::MAX_PAGES_DEF;
    localparam int ORDERS = bpa_pkg::ORDER_COUNT_DEF;
    localparam int IDX_W  = $clog2(PAGES);
    localparam int NO_LINK = PAGES;
    localparam int ORD_W  = bpa_pkg::ORDER_W;
    localparam int FRE_W  = bpa_pkg::FREE_W;
    localparam int CNT_W  = bpa_pkg::COUNT_W;
    localparam int BAS_W  = bpa_pkg::BASE_W;

    typedef struct packed {
        bpa_pkg::t_status   status;
        logic [IDX_W-1:0]   chunk;
        logic [FRE_W-1:0]   free_pages;
    } t_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_mode;
    logic [ORD_W-1:0]    i_order;
    logic [IDX_W-1:0]    i_page_index;
    logic                o_result_valid;
    logic [1:0]          o_status;
    logic [IDX_W-1:0]    o_chunk_index;
    logic [FRE_W-1:0]    o_free_pages;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic                i_cfg_index;
    logic [BAS_W-1:0]    i_cfg_data;

    buddy_page_allocator u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_order(i_order), .i_page_index(i_page_index),
        .o_result_valid(o_result_valid), .o_status(o_status),
        .o_chunk_index(o_chunk_index), .o_free_pages(o_free_pages),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // allocator state mirror
    logic [BAS_W-1:0]    pool_base;
    logic [CNT_W-1:0]    pool_count;
    bit                  head_free [PAGES];
    logic [ORD_W-1:0]    chunk_ord [PAGES];
    int                  next_pg [PAGES];
    int                  prev_pg [PAGES];
    int                  head_pg [ORDERS];
    logic [FRE_W-1:0]    free_cnt;

    t_result expected_results[$];
    int      held_chunks[$];
    int      errors;
    int      gap_pct;

    function automatic int pool_limit();
        return (pool_count < PAGES) ? int'(pool_count) : PAGES;
    endfunction

    function automatic bit buddy_of(input int idx, input int ord, output int bud);
        longint unsigned sz, ab, rel;
        sz = 64'd1 << ord;
        ab = (longint'(pool_base) + idx) ^ sz;
        bud = 0;
        if (ab < pool_base) return 0;
        rel = ab - pool_base;
        if (rel + sz > pool_limit()) return 0;
        bud = int'(rel);
        return 1;
    endfunction

    function automatic void push_chunk(input int ord, input int idx);
        int h;
        h = head_pg[ord];
        prev_pg[idx] = NO_LINK;
        next_pg[idx] = h;
        if (h < NO_LINK) prev_pg[h] = idx;
        head_pg[ord] = idx;
        head_free[idx] = 1;
        chunk_ord[idx] = ORD_W'(ord);
        free_cnt = free_cnt + (FRE_W'(1) << ord);
    endfunction

    function automatic void list_unlink(input int ord, input int idx);
        int n, p;
        n = next_pg[idx];
        p = prev_pg[idx];
        if (p < NO_LINK) next_pg[p] = n;
        else head_pg[ord] = n;
        if (n < NO_LINK) prev_pg[n] = p;
        head_free[idx] = 0;
        free_cnt = free_cnt - (FRE_W'(1) << ord);
    endfunction

    function automatic t_result predict_request(input bpa_pkg::t_mode md, input int want,
                                                input int pidx);
        t_result r;
        int ord, idx, bud;
        r.status = bpa_pkg::STAT_OK;
        r.chunk = '0;
        if (md == bpa_pkg::MODE_ALLOC) begin
            if (want >= ORDERS) begin
                r.status = bpa_pkg::STAT_BAD_ORDER;
            end else begin
                ord = want;
                while (ord < ORDERS && head_pg[ord] >= NO_LINK) ord++;
                if (ord >= ORDERS) begin
                    r.status = bpa_pkg::STAT_NO_FREE;
                end else begin
                    idx = head_pg[ord];
                    list_unlink(ord, idx);
                    while (ord > want) begin
                        ord--;
                        if (buddy_of(idx, ord, bud)) push_chunk(ord, bud);
                    end
                    chunk_ord[idx] = ORD_W'(want);
                    r.chunk = IDX_W'(idx);
                end
            end
        end else begin
            if (pidx >= pool_limit() || head_free[pidx]) begin
                r.status = bpa_pkg::STAT_BAD_INDEX;
            end else begin
                idx = pidx;
                ord = (chunk_ord[idx] >= ORDERS) ? ORDERS - 1 : int'(chunk_ord[idx]);
                while (ord + 1 < ORDERS) begin
                    if (!buddy_of(idx, ord, bud)) break;
                    if (!head_free[bud] || chunk_ord[bud] != ord) break;
                    list_unlink(ord, bud);
                    if (bud < idx) idx = bud;
                    ord++;
                end
                push_chunk(ord, idx);
            end
        end
        r.free_pages = free_cnt;
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_result_valid) begin
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result status %0d", o_status);
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status || o_chunk_index !== want.chunk ||
                    o_free_pages !== want.free_pages) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.status, want.chunk, want.free_pages,
                                 o_status, o_chunk_index, o_free_pages);
                end
            end
        end
    end

    task automatic send_request(input bpa_pkg::t_mode md, input int ord, input int pidx);
        t_result r;
        if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        start = 1'b1;
        i_mode = md;
        i_order = ORD_W'(ord);
        i_page_index = IDX_W'(pidx);
        do @(posedge i_clk); while (busy);
        r = predict_request(md, ord, pidx);
        if (md == bpa_pkg::MODE_ALLOC && r.status == bpa_pkg::STAT_OK)
            held_chunks.push_back(r.chunk);
        expected_results.push_back(r);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [BAS_W-1:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == bpa_pkg::CFG_BASE_PAGE) pool_base = val;
        else pool_count = val[CNT_W-1:0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_directed();
        gap_pct = 0;
        write_reg(bpa_pkg::CFG_BASE_PAGE, '0);
        write_reg(bpa_pkg::CFG_PAGE_COUNT, BAS_W'(16));
        for (int p = 0; p < 16; p++) send_request(bpa_pkg::MODE_FREE, 0, p);
        send_request(bpa_pkg::MODE_ALLOC, 15, 0);
        send_request(bpa_pkg::MODE_ALLOC, 0, 0);
        send_request(bpa_pkg::MODE_ALLOC, 4, 0);
        send_request(bpa_pkg::MODE_FREE, 0, 1);
        send_request(bpa_pkg::MODE_FREE, 0, 4095);
        send_request(bpa_pkg::MODE_FREE, 0, 0);
        send_request(bpa_pkg::MODE_ALLOC, 2, 0);
        send_request(bpa_pkg::MODE_FREE, 0, 2);
        drain();
    endtask

    task automatic test_random(input logic [BAS_W-1:0] base, input logic [CNT_W-1:0] cnt,
                               input int n_items, input int gap);
        int lim, k, pick;
        write_reg(bpa_pkg::CFG_BASE_PAGE, base);
        write_reg(bpa_pkg::CFG_PAGE_COUNT, BAS_W'(cnt));
        gap_pct = gap;
        lim = pool_limit();
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(9) == 0) start = 1'b0;
            k = $urandom_range(99);
            if (k < 35) begin
                send_request(bpa_pkg::MODE_ALLOC,
                             ($urandom_range(7) == 0) ? $urandom_range(15)
                                                      : $urandom_range(3), 0);
            end else if (k < 65 && held_chunks.size() != 0) begin
                pick = $urandom_range(held_chunks.size() - 1);
                send_request(bpa_pkg::MODE_FREE, $urandom_range(15), held_chunks[pick]);
                held_chunks.delete(pick);
            end else if (k < 92 && lim > 0) begin
                send_request(bpa_pkg::MODE_FREE, 0, $urandom_range(lim - 1));
            end else begin
                send_request(bpa_pkg::MODE_FREE, 0, $urandom_range(PAGES - 1));
            end
        end
        drain();
    endtask

    initial begin
        errors = 0;
        gap_pct = 0;
        start = 1'b0;
        i_mode = bpa_pkg::MODE_ALLOC;
        i_order = '0;
        i_page_index = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = bpa_pkg::CFG_BASE_PAGE;
        i_cfg_data = '0;
        pool_base = '0;
        pool_count = '0;
        free_cnt = '0;
        for (int p = 0; p < PAGES; p++) begin
            head_free[p] = 0;
            chunk_ord[p] = '0;
            next_pg[p] = 0;
            prev_pg[p] = 0;
        end
        for (int o = 0; o < ORDERS; o++) head_pg[o] = NO_LINK;
        i_rst_n = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random('0, 13'd4096, 300, 28);
        test_random({BAS_W{1'b1}}, {CNT_W{1'b1}}, 300, 71);
        test_random(BAS_W'({$urandom, $urandom}), CNT_W'($urandom_range(32, 600)),
                    300, 0);
        test_random(BAS_W'(5), CNT_W'(100), 300, 28);
        test_random(BAS_W'(3), CNT_W'(0), 40, 71);
        test_random(BAS_W'({$urandom, $urandom}), 13'd4096, 200, 0);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
